// File: rtl/stream_find_replace_macros.svh
// ---------------------------------------------------------------------------
// stream_find_replace_macros.svh
// Assertion macros used by the checker file of the find/replace block.
// ---------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH

// Overlapping implication, masked while reset is high.
`define SFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication with no reset mask, for checks on reset itself.
`define SFR_ASSERT_RAW(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sfr_pkg.sv
// ---------------------------------------------------------------------------
// sfr_pkg
// Types and constants of the stream find/replace block.
// ---------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int REPLACE_MAX = 8;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 4;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 5;
  localparam int QUEUE_DEPTH = 2;

  // Register indexes, taken from paddr[4:3]
  localparam logic [1:0] REG_PATTERN_LEN   = 2'd0;
  localparam logic [1:0] REG_PATTERN_BYTES = 2'd1;
  localparam logic [1:0] REG_REPLACE_LEN   = 2'd2;
  localparam logic [1:0] REG_REPLACE_BYTES = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  pattern_len;
    logic [DATA_W-1:0] pattern_bytes;
    logic [CNT_W-1:0]  replace_len;
    logic [DATA_W-1:0] replace_bytes;
  } cfg_t;

  // One emission request from the front to the back
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              last;
  } job_t;

endpackage

`default_nettype wire

// File: rtl/stream_find_replace.sv
// ---------------------------------------------------------------------------
// stream_find_replace
// Streaming search-and-replace-all over a byte text.
// ---------------------------------------------------------------------------
// Each pushed byte is classified in the cycle it is accepted: bytes that may
// still start a match are held back, a completed match becomes the
// replacement, and everything else is released as literal text. The runs
// wait in a two-entry queue and are emitted one result per cycle while the
// receiver pops, so input is taken every cycle while the queue has room; an
// item that causes several results occupies the single byte-wide output
// stage until all are out. A final byte that leaves no text yields one end
// marker with has_byte low. Registers sit at byte addresses 0, 8, 16, 24;
// writing either pattern register drops any held bytes. There is no
// clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module stream_find_replace (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire sfr_pkg::in_item_t          item,
  output logic                            empty,
  input  wire logic                       pop,
  output sfr_pkg::out_item_t              result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sfr_pkg::DATA_W-1:0] pwdata,
  output logic      [sfr_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  sfr_pkg::cfg_t cfg;
  sfr_pkg::job_t front_job;
  sfr_pkg::job_t q_job;
  logic          pattern_clear;
  logic          accept;
  logic          job_push;
  logic          q_valid;
  logic          q_take;

  assign accept = push && !full;

  sfr_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .cfg           (cfg),
    .pattern_clear (pattern_clear)
  );

  sfr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (item),
    .cfg           (cfg),
    .pattern_clear (pattern_clear),
    .job_push      (job_push),
    .job           (front_job)
  );

  sfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_job   (front_job),
    .full     (full),
    .rd_en    (q_take),
    .rd_job   (q_job),
    .rd_valid (q_valid)
  );

  sfr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_take  (q_take),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

// File: rtl/sfr_cfg.sv
// ---------------------------------------------------------------------------
// sfr_cfg
// APB-style register file: pattern and replacement lengths and bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sfr_pkg::DATA_W-1:0] pwdata,
  output logic      [sfr_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output sfr_pkg::cfg_t                   cfg,
  output logic                            pattern_clear
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_len   <= sfr_pkg::CNT_W'(1);
      cfg.pattern_bytes <= '0;
      cfg.replace_len   <= '0;
      cfg.replace_bytes <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        sfr_pkg::REG_PATTERN_LEN:   cfg.pattern_len   <= pwdata[sfr_pkg::CNT_W-1:0];
        sfr_pkg::REG_PATTERN_BYTES: cfg.pattern_bytes <= pwdata;
        sfr_pkg::REG_REPLACE_LEN:   cfg.replace_len   <= pwdata[sfr_pkg::CNT_W-1:0];
        sfr_pkg::REG_REPLACE_BYTES: cfg.replace_bytes <= pwdata;
        default: ;
      endcase
    end
  end

  // A new pattern invalidates any partly matched bytes
  assign pattern_clear = wr_en && (reg_idx == sfr_pkg::REG_PATTERN_LEN ||
                                   reg_idx == sfr_pkg::REG_PATTERN_BYTES);

  always_comb begin
    case (reg_idx)
      sfr_pkg::REG_PATTERN_LEN:
        prdata = sfr_pkg::DATA_W'(cfg.pattern_len);
      sfr_pkg::REG_PATTERN_BYTES:
        prdata = cfg.pattern_bytes;
      sfr_pkg::REG_REPLACE_LEN:
        prdata = sfr_pkg::DATA_W'(cfg.replace_len);
      sfr_pkg::REG_REPLACE_BYTES:
        prdata = cfg.replace_bytes;
      default:
        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/sfr_front.sv
// ---------------------------------------------------------------------------
// sfr_front
// Holds back possible pattern prefixes and classifies each incoming byte
// into a run of bytes to emit: literal text or the replacement.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire sfr_pkg::in_item_t item,
  input  wire sfr_pkg::cfg_t     cfg,
  input  wire logic              pattern_clear,
  output logic                   job_push,
  output sfr_pkg::job_t          job
);

  logic [sfr_pkg::DATA_W-1:0] held;
  logic [sfr_pkg::CNT_W-1:0]  held_count;
  logic [sfr_pkg::DATA_W-1:0] held_next;
  logic [sfr_pkg::CNT_W-1:0]  held_count_next;

  logic [sfr_pkg::DATA_W-1:0]      seq;
  logic [sfr_pkg::CNT_W-1:0]       n;
  logic [sfr_pkg::CNT_W-1:0]       plen;
  logic [sfr_pkg::CNT_W-1:0]       rlen;
  logic [sfr_pkg::PATTERN_MAX-1:0] pref;
  logic [sfr_pkg::CNT_W-1:0]       hold_from;
  logic                            full_match;

  // Clamp lengths into range
  always_comb begin
    if (cfg.pattern_len == '0)
      plen = sfr_pkg::CNT_W'(1);
    else if (cfg.pattern_len > sfr_pkg::CNT_W'(sfr_pkg::PATTERN_MAX))
      plen = sfr_pkg::CNT_W'(sfr_pkg::PATTERN_MAX);
    else
      plen = cfg.pattern_len;
    if (cfg.replace_len > sfr_pkg::CNT_W'(sfr_pkg::REPLACE_MAX))
      rlen = sfr_pkg::CNT_W'(sfr_pkg::REPLACE_MAX);
    else
      rlen = cfg.replace_len;
  end

  assign n = held_count + sfr_pkg::CNT_W'(1);

  // Held bytes followed by the new byte
  always_comb begin
    for (int i = 0; i < sfr_pkg::PATTERN_MAX; i++) begin
      if (sfr_pkg::CNT_W'(i) < held_count)
        seq[8*i +: 8] = held[8*i +: 8];
      else
        seq[8*i +: 8] = item.in_byte;
    end
  end

  // pref[p]: the tail of the sequence from p on agrees with the pattern head
  always_comb begin
    for (int p = 0; p < sfr_pkg::PATTERN_MAX; p++) begin
      pref[p] = sfr_pkg::CNT_W'(p) < n;
      for (int i = 0; i < sfr_pkg::PATTERN_MAX - p; i++) begin
        if (sfr_pkg::CNT_W'(p + i) < n && sfr_pkg::CNT_W'(i) < plen &&
            seq[8*(p+i) +: 8] != cfg.pattern_bytes[8*i +: 8])
          pref[p] = 1'b0;
      end
    end
  end

  assign full_match = pref[0] && (n >= plen);

  // Leftmost possible match start, or the sequence end if none
  always_comb begin
    hold_from = n;
    for (int p = sfr_pkg::PATTERN_MAX - 1; p >= 0; p--) begin
      if (pref[p])
        hold_from = sfr_pkg::CNT_W'(p);
    end
  end

  always_comb begin
    job.last        = item.in_last;
    held_next       = seq >> {hold_from, 3'b000};
    held_count_next = '0;
    if (full_match) begin
      job.data  = cfg.replace_bytes;
      job.count = rlen;
    end else if (item.in_last) begin
      job.data  = seq;
      job.count = n;
    end else begin
      job.data        = seq;
      job.count       = hold_from;
      held_count_next = n - hold_from;
    end
  end

  // Drop runs that emit nothing unless they close the text
  assign job_push = accept && (job.count != '0 || job.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (pattern_clear) begin
      held_count <= '0;
    end else if (accept) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sfr_queue.sv
// ---------------------------------------------------------------------------
// sfr_queue
// Short job queue between the classifying front and the emitting back.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_queue (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    wr_en,
  input  wire sfr_pkg::job_t wr_job,
  output logic         full,
  input  wire logic    rd_en,
  output sfr_pkg::job_t rd_job,
  output logic         rd_valid
);

  localparam int PTR_W = (sfr_pkg::QUEUE_DEPTH > 1) ? $clog2(sfr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(sfr_pkg::QUEUE_DEPTH + 1);

  sfr_pkg::job_t    slots [sfr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == CNT_W'(sfr_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(sfr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(sfr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sfr_back.sv
// ---------------------------------------------------------------------------
// sfr_back
// Takes one job at a time from the queue and emits its bytes, one result a
// cycle while the receiver pops, from a registered run buffer.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire sfr_pkg::job_t q_job,
  output logic               q_take,
  output logic               empty,
  input  wire logic          pop,
  output sfr_pkg::out_item_t result
);

  logic                       cur_valid;
  logic [sfr_pkg::DATA_W-1:0] cur_data;
  logic [sfr_pkg::CNT_W-1:0]  cur_rem;
  logic                       cur_last;
  logic                       final_one;
  logic                       advance;

  assign empty     = !cur_valid;
  assign final_one = (cur_rem <= sfr_pkg::CNT_W'(1));
  assign advance   = cur_valid && pop;
  assign q_take    = q_valid && (!cur_valid || (advance && final_one));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (q_take) begin
      cur_valid <= 1'b1;
    end else if (advance && final_one) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      cur_data <= q_job.data;
      cur_rem  <= q_job.count;
      cur_last <= q_job.last;
    end else if (advance && !final_one) begin
      // shift the next byte down
      cur_data <= cur_data >> sfr_pkg::BYTE_W;
      cur_rem  <= cur_rem - sfr_pkg::CNT_W'(1);
    end
  end

  // An empty run shows as an end marker with a zero byte
  assign result.has_byte = (cur_rem != '0);
  assign result.out_byte = result.has_byte ? cur_data[7:0] : 8'd0;
  assign result.run_last = final_one;
  assign result.text_end = cur_last && final_one;

endmodule

`default_nettype wire

// File: rtl/sfr_checker.sv
// ---------------------------------------------------------------------------
// sfr_props
// Port-level checks of the find/replace block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "stream_find_replace_macros.svh"

module sfr_props (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       full,
  input wire logic                       empty,
  input wire logic                       pop,
  input wire sfr_pkg::out_item_t         result
);

  // A waiting result holds until taken
  `SFR_ASSERT_NEXT(a_result_hold, clk, rst, !empty && !pop, !empty && $stable(result), "result changed while stalled")

  // The end of the text always closes a run
  `SFR_ASSERT_NOW(a_end_closes_run, clk, rst, !empty && result.text_end, result.run_last, "text_end without run_last")

  // An empty result is only ever the end marker, with a zero byte
  `SFR_ASSERT_NOW(a_marker_form, clk, rst, !empty && !result.has_byte, result.text_end && result.out_byte == 8'd0, "malformed end marker")

  // Reset leaves no result and room for input
  `SFR_ASSERT_RAW(a_reset_clear, clk, rst, empty && !full, "not clear after reset")

endmodule

bind stream_find_replace sfr_props u_sfr_checker (.*);

`default_nettype wire

// File: tb/sv/sfr_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfr_checker
// Watches the byte, result and register channels of stream_find_replace,
// keeps its own copy of the search state and the four registers, works out
// the output text for every accepted request and compares each popped
// result with the oldest one still owed.
// ---------------------------------------------------------------------------

module sfr_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic                         full,
  input  sfr_pkg::in_item_t            item,
  input  logic                         pop,
  input  logic                         empty,
  input  sfr_pkg::out_item_t           result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [sfr_pkg::ADDR_W-1:0]   paddr,
  input  logic [sfr_pkg::DATA_W-1:0]   pwdata,
  output int                           fail_count,
  output int                           pending,
  output int                           checked
);
  import sfr_pkg::*;

  localparam int REPORT_MAX = 10;

  logic [CNT_W-1:0]  pat_len;
  logic [DATA_W-1:0] pat_text;
  logic [CNT_W-1:0]  rep_len;
  logic [DATA_W-1:0] rep_text;
  logic [7:0]        held_text [PATTERN_MAX];
  int                held_len;

  out_item_t         owed_text [$];
  out_item_t         want;
  int                fails = 0;
  int                reported = 0;
  int                n_checked = 0;

  // Scan one byte against the held prefix and queue the text it releases
  task automatic scan_byte(input in_item_t it);
    logic [7:0] seq [PATTERN_MAX+1];
    logic [7:0] emitted [8];
    int         n, pos, cnt, hold_from, plen, rlen, rem, k;
    bit         prefix;
    out_item_t  r;
    n = 0;
    pos = 0;
    cnt = 0;
    plen = (pat_len == 0) ? 1 : ((pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len));
    rlen = (rep_len > REPLACE_MAX) ? REPLACE_MAX : int'(rep_len);
    for (int i = 0; i < held_len; i++) begin
      seq[n] = held_text[i];
      n++;
    end
    seq[n] = it.in_byte;
    n++;
    hold_from = n;
    while (pos < n) begin
      rem = n - pos;
      k = (rem < plen) ? rem : plen;
      prefix = 1'b1;
      for (int i = 0; i < k; i++)
        if (seq[pos+i] != pat_text[8*i +: 8]) prefix = 1'b0;
      if (prefix && rem >= plen) begin
        for (int i = 0; i < rlen; i++) begin
          if (cnt < 8) emitted[cnt] = rep_text[8*i +: 8];
          cnt++;
        end
        pos += plen;
      end else if (prefix && !it.in_last) begin
        hold_from = pos;
        break;
      end else begin
        if (cnt < 8) emitted[cnt] = seq[pos];
        cnt++;
        pos++;
      end
    end
    if (cnt > 8) cnt = 8;
    held_len = 0;
    for (int i = hold_from; i < n; i++) begin
      if (held_len < PATTERN_MAX) begin
        held_text[held_len] = seq[i];
        held_len++;
      end
    end
    if (cnt == 0) begin
      if (it.in_last) begin
        r = {8'h00, 1'b0, 1'b1, 1'b1};
        owed_text.push_back(r);
      end
    end else begin
      for (int i = 0; i < cnt; i++) begin
        r.out_byte = emitted[i];
        r.has_byte = 1'b1;
        r.run_last = (i == cnt - 1);
        r.text_end = (i == cnt - 1) && it.in_last;
        owed_text.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pat_len = 4'd1;
      pat_text = '0;
      rep_len = '0;
      rep_text = '0;
      held_len = 0;
      owed_text.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_PATTERN_LEN: begin
            pat_len = pwdata[CNT_W-1:0];
            held_len = 0;
          end
          REG_PATTERN_BYTES: begin
            pat_text = pwdata;
            held_len = 0;
          end
          REG_REPLACE_LEN:   rep_len = pwdata[CNT_W-1:0];
          REG_REPLACE_BYTES: rep_text = pwdata;
          default: ;
        endcase
      end
      if (push && !full) scan_byte(item);
      if (pop && !empty) begin
        if (owed_text.size() == 0) begin
          fails++;
          if (reported < REPORT_MAX)
            $display("unexpected result: byte %02h has %0b run_last %0b end %0b",
                     result.out_byte, result.has_byte, result.run_last, result.text_end);
          reported++;
        end else begin
          want = owed_text.pop_front();
          if (result !== want) begin
            fails++;
            if (reported < REPORT_MAX)
              $display({"mismatch at result %0d: expected byte %02h has %0b run_last %0b ",
                        "end %0b, got byte %02h has %0b run_last %0b end %0b"},
                       n_checked, want.out_byte, want.has_byte, want.run_last,
                       want.text_end, result.out_byte, result.has_byte,
                       result.run_last, result.text_end);
            reported++;
          end
          n_checked++;
        end
      end
    end
    fail_count <= fails;
    pending    <= owed_text.size();
    checked    <= n_checked;
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench of stream_find_replace: a short directed run over the default
// settings, length limits and a pattern rewrite mid-text, then random texts
// built from pattern copies, broken prefixes and noise under a series of
// register settings, with bursty input and a stalling receiver.
// ---------------------------------------------------------------------------

module tb_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 320;
  localparam int SETTLE       = 8;

  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       push;
  logic                       full;
  sfr_pkg::in_item_t          item;
  logic                       empty;
  logic                       pop;
  sfr_pkg::out_item_t         result;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [sfr_pkg::ADDR_W-1:0] paddr;
  logic [sfr_pkg::DATA_W-1:0] pwdata;
  logic [sfr_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  int                fail_count;
  int                pending;
  int                checked;
  int                cycle_count = 0;
  int                burst_left = 0;
  bit                no_gaps = 1'b0;
  int                texts_sent = 0;
  int                bytes_sent = 0;
  int                settings_used = 0;
  logic [7:0]        text_buf [$];

  rx_mode_t          rx_mode = RX_STREAM;
  int                rx_left = 0;
  int                rx_tick = 0;

  stream_find_replace u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sfr_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .pop        (pop),
    .empty      (empty),
    .result     (result),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: switch at random between four stall patterns
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_STREAM: pop <= 1'b1;
        RX_COIN:   pop <= 1'($urandom_range(0, 1));
        RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
        default:   pop <= ((rx_tick % 5) < 2);
      endcase
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [sfr_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Lengths carry random upper bits; only the low nibble is stored
  task automatic load_settings(input logic [3:0] plen, input logic [63:0] pat,
                               input logic [3:0] rlen, input logic [63:0] rep);
    write_reg(sfr_pkg::REG_PATTERN_LEN, {$urandom, 4'($urandom_range(0, 15)), 24'h0, plen});
    write_reg(sfr_pkg::REG_PATTERN_BYTES, pat);
    write_reg(sfr_pkg::REG_REPLACE_LEN, {$urandom, 4'($urandom_range(0, 15)), 24'h0, rlen});
    write_reg(sfr_pkg::REG_REPLACE_BYTES, rep);
    settings_used++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    push <= 1'b1;
    item <= {b, last};
    do @(posedge clk); while (full);
    bytes_sent++;
    if (last) texts_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  // Hold input until every owed result has come, then let the block settle
  task automatic drain_and_hold();
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    logic [3:0]  plen_w;
    logic [3:0]  rlen_w;
    logic [63:0] pat_w;
    logic [63:0] rep_w;
    logic [7:0]  alpha [3];
    int          plen_eff;
    int          target;
    int          piece;
    int          cut;
    int          n_texts;
    int          rand_items;

    rst     = 1'b1;
    push    = 1'b0;
    item    = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default settings: a single zero byte is deleted, text ending in nothing
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    drain_and_hold();

    load_settings(4'd3, 64'h616261, 4'd2, 64'h5958);
    text_buf = '{8'h61, 8'h62, 8'h61, 8'h62, 8'h61};
    send_text();
    text_buf = '{8'h61, 8'h62, 8'h7A};
    send_text();

    // Drop a held prefix by rewriting the pattern mid-text
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    drain_and_hold();
    write_reg(sfr_pkg::REG_PATTERN_BYTES, 64'h616261);
    send_byte(8'h61, 1'b1);
    drain_and_hold();

    // Pattern length zero acts as one, replacement length over range as eight
    load_settings(4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h00FF_7F80_01FE_55AA);
    send_byte(8'hFF, 1'b1);
    drain_and_hold();

    // Over-long pattern length acts as eight; break the prefix at its end
    pat_w = 64'hFF01_0203_0405_0600;
    load_settings(4'd15, pat_w, 4'd0, 64'h0);
    for (int i = 0; i < 7; i++) send_byte(pat_w[8*i +: 8], 1'b0);
    send_byte(8'hAA, 1'b1);
    drain_and_hold();

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      for (int i = 0; i < 3; i++) alpha[i] = 8'($urandom_range(0, 255));
      for (int i = 0; i < 8; i++) pat_w[8*i +: 8] = alpha[$urandom_range(0, 2)];
      if ($urandom_range(0, 5) == 0) pat_w = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0:       plen_w = 4'd0;
        1:       plen_w = 4'd1;
        2:       plen_w = 4'd8;
        3:       plen_w = 4'($urandom_range(9, 15));
        default: plen_w = 4'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
        0:       rlen_w = 4'd0;
        1:       rlen_w = 4'd8;
        2:       rlen_w = 4'($urandom_range(9, 15));
        default: rlen_w = 4'($urandom_range(0, 8));
      endcase
      rep_w = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0:       rep_w = '0;
        1:       rep_w = '1;
        default: ;
      endcase
      plen_eff = (plen_w == 0) ? 1 : ((plen_w > 8) ? 8 : int'(plen_w));
      load_settings(plen_w, pat_w, rlen_w, rep_w);
      no_gaps = ($urandom_range(0, 3) == 0);

      n_texts = $urandom_range(1, 4);
      for (int t = 0; t < n_texts; t++) begin
        text_buf.delete();
        target = $urandom_range(1, 20);
        while (text_buf.size() < target) begin
          piece = $urandom_range(0, 9);
          if (piece < 4) begin
            for (int i = 0; i < plen_eff; i++) text_buf.push_back(pat_w[8*i +: 8]);
          end else if (piece < 6) begin
            cut = (plen_eff > 1) ? $urandom_range(1, plen_eff - 1) : 1;
            for (int i = 0; i < cut; i++) text_buf.push_back(pat_w[8*i +: 8]);
          end else if (piece < 9) begin
            text_buf.push_back(alpha[$urandom_range(0, 2)]);
          end else begin
            text_buf.push_back(8'($urandom_range(0, 255)));
          end
        end
        send_text();
        rand_items += text_buf.size();
      end
      drain_and_hold();
    end

    repeat (16) @(negedge clk);
    $display("Pushed %0d bytes in %0d texts under %0d register settings.",
             bytes_sent, texts_sent, settings_used);
    $display("Compared %0d output results, %0d failures.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
